### rtl/grid_peak_cell_finder_assert.svh
// ----------------------------------------------------------------------------
// grid_peak_cell_finder assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRID_PEAK_CELL_FINDER_ASSERT_SVH
`define GRID_PEAK_CELL_FINDER_ASSERT_SVH

// same-cycle implication
`define GPCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gpcf_pkg.sv
// ----------------------------------------------------------------------------
// gpcf_pkg
// Shared types and constants of the grid peak cell finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpcf_pkg;

  localparam int unsigned CELL_W    = 32;
  localparam int unsigned DIM_W     = 7;
  localparam int unsigned PEAK_W    = 6;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic signed [CELL_W-1:0] cell_t;
  typedef logic [DIM_W-1:0]         dim_t;
  typedef logic [PEAK_W-1:0]        peak_idx_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS = 2'd0,
    CFG_NUM_COLS = 2'd1
  } cfg_reg_e;

  // one line store word: the two most recent rows at a column
  typedef struct packed {
    cell_t up1;  // row r-1
    cell_t up2;  // row r-2
  } line_entry_t;

  typedef struct packed {
    peak_idx_t row;
    peak_idx_t col;
  } peak_t;

  // position flags of the cell in the judge stage
  typedef struct packed {
    logic valid;
    logic restart;
    logic row_gt0;
    logic row_gt1;
    logic col_gt0;
    logic col_gt1;
    logic col_lt_last;
    logic last_row;
    logic last_col;
  } stage_ctl_t;

endpackage

### rtl/gpcf_if.sv
// ----------------------------------------------------------------------------
// gpcf interfaces
// Valid/ready channels for cells, peak results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gpcf_cell_if;
  import gpcf_pkg::*;
  logic  valid;
  logic  ready;
  cell_t cell_value;
  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface gpcf_peak_if;
  import gpcf_pkg::*;
  logic      valid;
  logic      ready;
  peak_idx_t peak_row;
  peak_idx_t peak_col;
  modport source (output valid, output peak_row, output peak_col, input ready);
  modport sink   (input valid, input peak_row, input peak_col, output ready);
endinterface

interface gpcf_cfg_if;
  import gpcf_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  dim_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/grid_peak_cell_finder.sv
// ----------------------------------------------------------------------------
// grid_peak_cell_finder
// Streams a grid of signed cells and reports the first peak in row-major order.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i  : register writes, index 0 = num_rows, 1 = num_cols (0 acts as 1,
//            values above MAX_ROWS / MAX_COLS are clipped). A write to index 0
//            or 1 restarts the grid. Write only while no cell is in flight.
//   cell_i : one cell per transaction, row-major. One per cycle unless stalled.
//   peak_o : one transaction per grid carrying the peak row and column.
// Timing: the result is registered in the judge stage and in the result queue
//   before it is valid. Cells are judged in the cycle after acceptance, using
//   a line store with one word per column read one column ahead; throughput is
//   one cell per cycle, bound by its single read port, save final-cell stalls.
// Stall: results queue in a two-entry buffer; only a final cell waits when
//   that buffer is full, all other cells keep flowing.
// Reset: both dimensions return to 1 and the grid position to row 0, col 0.
//   The line store is not cleared; only words written in the current grid
//   are ever compared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_peak_cell_finder #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gpcf_cfg_if.sink          cfg_i,
  gpcf_cell_if.sink         cell_i,
  gpcf_peak_if.source       peak_o
);
  import gpcf_pkg::*;

  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [RowW-1:0] rows_last_q, rows_last_d;
  logic [ColW-1:0] cols_last_q, cols_last_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic            cfg_fire;
  logic            cfg_hit;

  logic            restart;
  logic [RowW-1:0] row_eff;
  logic [ColW-1:0] col_eff;
  logic            at_last_row, at_last_col, at_final;
  logic            cell_fire;
  logic [ColW-1:0] raddr;

  stage_ctl_t      s1_ctl_q, s1_ctl_d;
  logic [RowW-1:0] s1_row_q;
  logic [ColW-1:0] s1_col_q;
  cell_t           s1_value_q;

  line_entry_t     rdata;
  logic            mem_we;
  logic [ColW-1:0] mem_waddr;
  line_entry_t     mem_wdata;
  logic            push;
  peak_t           push_data;
  peak_t           head;
  logic            head_valid;
  logic [1:0]      queue_count;
  logic            pend;
  logic            pop;
  logic [2:0]      occ;
  logic            room;

  // configuration
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  always_comb begin
    rows_last_d = rows_last_q;
    cols_last_d = cols_last_q;
    cfg_hit     = 1'b0;
    if (cfg_fire) begin
      case (cfg_i.index)
        CFG_NUM_ROWS: begin
          cfg_hit = 1'b1;
          if (cfg_i.data == '0) begin
            rows_last_d = '0;
          end else if (32'(cfg_i.data) > MAX_ROWS) begin
            rows_last_d = RowW'(MAX_ROWS - 1);
          end else begin
            rows_last_d = RowW'(cfg_i.data - DIM_W'(1));
          end
        end
        CFG_NUM_COLS: begin
          cfg_hit = 1'b1;
          if (cfg_i.data == '0) begin
            cols_last_d = '0;
          end else if (32'(cfg_i.data) > MAX_COLS) begin
            cols_last_d = ColW'(MAX_COLS - 1);
          end else begin
            cols_last_d = ColW'(cfg_i.data - DIM_W'(1));
          end
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // input position
  always_comb begin
    restart     = (row_q > rows_last_q) || (col_q > cols_last_q);
    row_eff     = restart ? '0 : row_q;
    col_eff     = restart ? '0 : col_q;
    at_last_row = (row_eff == rows_last_q);
    at_last_col = (col_eff == cols_last_q);
    at_final    = at_last_row && at_last_col;
    raddr       = at_last_col ? '0 : ColW'(col_eff + ColW'(1));
  end

  // result queue credit: a final cell needs a free slot by the time it lands
  assign pend = s1_ctl_q.valid && s1_ctl_q.last_row && s1_ctl_q.last_col;
  assign pop  = head_valid && peak_o.ready;
  assign occ  = {1'b0, queue_count} + {2'b00, pend};
  assign room = (occ <= 3'd1) || ((occ == 3'd2) && pop);

  assign cell_i.ready = !at_final || room;
  assign cell_fire    = cell_i.valid && cell_i.ready;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_hit) begin
      row_d = '0;
      col_d = '0;
    end else if (cell_fire) begin
      if (at_final) begin
        row_d = '0;
        col_d = '0;
      end else if (at_last_col) begin
        row_d = RowW'(row_eff + RowW'(1));
        col_d = '0;
      end else begin
        row_d = row_eff;
        col_d = ColW'(col_eff + ColW'(1));
      end
    end
  end

  always_comb begin
    s1_ctl_d             = '0;
    s1_ctl_d.valid       = cell_fire;
    s1_ctl_d.restart     = restart;
    s1_ctl_d.row_gt0     = (row_eff != '0);
    s1_ctl_d.row_gt1     = (row_eff > RowW'(1));
    s1_ctl_d.col_gt0     = (col_eff != '0);
    s1_ctl_d.col_gt1     = (col_eff > ColW'(1));
    s1_ctl_d.col_lt_last = !at_last_col;
    s1_ctl_d.last_row    = at_last_row;
    s1_ctl_d.last_col    = at_last_col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_last_q <= '0;
      cols_last_q <= '0;
      row_q       <= '0;
      col_q       <= '0;
      s1_ctl_q    <= '0;
    end else begin
      rows_last_q <= rows_last_d;
      cols_last_q <= cols_last_d;
      row_q       <= row_d;
      col_q       <= col_d;
      s1_ctl_q    <= s1_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_fire) begin
      s1_row_q   <= row_eff;
      s1_col_q   <= col_eff;
      s1_value_q <= cell_i.cell_value;
    end
  end

  gpcf_line_mem #(
    .Depth (MAX_COLS)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (cell_fire),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  gpcf_judge #(
    .MaxRows (MAX_ROWS),
    .MaxCols (MAX_COLS)
  ) u_judge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_hit),
    .ctl_i       (s1_ctl_q),
    .row_i       (s1_row_q),
    .col_i       (s1_col_q),
    .value_i     (s1_value_q),
    .rows_last_i (rows_last_q),
    .rdata_i     (rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .push_o      (push),
    .push_data_o (push_data)
  );

  gpcf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (peak_o.ready),
    .valid_o     (head_valid),
    .data_o      (head),
    .count_o     (queue_count)
  );

  assign peak_o.valid    = head_valid;
  assign peak_o.peak_row = head.row;
  assign peak_o.peak_col = head.col;

endmodule

### rtl/gpcf_line_mem.sv
// ----------------------------------------------------------------------------
// gpcf_line_mem
// Line store: one word per column, one write and one registered read port,
// write data bypassed to a read of the same address in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpcf_line_mem #(
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  gpcf_pkg::line_entry_t wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output gpcf_pkg::line_entry_t rdata_o
);
  import gpcf_pkg::*;

  line_entry_t mem [Depth];
  line_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/gpcf_judge.sv
// ----------------------------------------------------------------------------
// gpcf_judge
// Peak test stage: judges the cell above the arriving one and, on the last
// row, the arriving row itself; keeps the column window and the held peak.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpcf_judge #(
  parameter int unsigned MaxRows = 64,
  parameter int unsigned MaxCols = 64,
  localparam int unsigned RowW = (MaxRows > 1) ? $clog2(MaxRows) : 1,
  localparam int unsigned ColW = (MaxCols > 1) ? $clog2(MaxCols) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  gpcf_pkg::stage_ctl_t  ctl_i,
  input  logic [RowW-1:0]       row_i,
  input  logic [ColW-1:0]       col_i,
  input  gpcf_pkg::cell_t       value_i,
  input  logic [RowW-1:0]       rows_last_i,
  input  gpcf_pkg::line_entry_t rdata_i,
  output logic                  mem_we_o,
  output logic [ColW-1:0]       mem_waddr_o,
  output gpcf_pkg::line_entry_t mem_wdata_o,
  output logic                  push_o,
  output gpcf_pkg::peak_t       push_data_o
);
  import gpcf_pkg::*;

  line_entry_t     win_q, win_d;
  cell_t           left_up_q;
  cell_t           prev_v_q;
  cell_t           prev2_v_q;
  logic            seen_q, seen_d;
  logic [RowW-1:0] held_row_q, held_row_d;
  logic [ColW-1:0] held_col_q, held_col_d;

  logic            pk_a, pk_b, pk_c;
  logic            seen_c;
  logic [RowW-1:0] hr_c;
  logic [ColW-1:0] hc_c;
  logic            final_cell;

  assign final_cell = ctl_i.last_row && ctl_i.last_col;

  always_comb begin
    seen_c = ctl_i.restart ? 1'b0 : seen_q;
    hr_c   = held_row_q;
    hc_c   = held_col_q;

    // cell above the arriving one
    pk_a = ctl_i.row_gt0
        && (!ctl_i.row_gt1 || (win_q.up1 >= win_q.up2))
        && (!ctl_i.col_gt0 || (win_q.up1 >= left_up_q))
        && (!ctl_i.col_lt_last || (win_q.up1 >= rdata_i.up1))
        && (win_q.up1 >= value_i);
    if (pk_a && (!seen_c || (hr_c == rows_last_i))) begin
      seen_c = 1'b1;
      hr_c   = RowW'(row_i - RowW'(1));
      hc_c   = col_i;
    end

    // last row, left of the arriving cell
    pk_b = ctl_i.last_row && ctl_i.col_gt0
        && (!ctl_i.row_gt0 || (prev_v_q >= left_up_q))
        && (!ctl_i.col_gt1 || (prev_v_q >= prev2_v_q))
        && (prev_v_q >= value_i);
    if (pk_b && !seen_c) begin
      seen_c = 1'b1;
      hr_c   = row_i;
      hc_c   = ColW'(col_i - ColW'(1));
    end

    // last row, last column: the arriving cell itself
    pk_c = ctl_i.last_row && ctl_i.last_col
        && (!ctl_i.row_gt0 || (value_i >= win_q.up1))
        && (!ctl_i.col_gt0 || (value_i >= prev_v_q));
    if (pk_c && !seen_c) begin
      seen_c = 1'b1;
      hr_c   = row_i;
      hc_c   = col_i;
    end
  end

  always_comb begin
    seen_d     = seen_q;
    held_row_d = held_row_q;
    held_col_d = held_col_q;
    if (clear_i) begin
      seen_d     = 1'b0;
      held_row_d = '0;
      held_col_d = '0;
    end else if (ctl_i.valid) begin
      if (final_cell) begin
        seen_d     = 1'b0;
        held_row_d = '0;
        held_col_d = '0;
      end else begin
        seen_d     = seen_c;
        held_row_d = hr_c;
        held_col_d = hc_c;
      end
    end
  end

  // one-column grid: next read hits the word written now
  always_comb begin
    if (ctl_i.last_col && !ctl_i.col_gt0) begin
      win_d = '{up1: value_i, up2: win_q.up1};
    end else begin
      win_d = rdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      held_row_q <= '0;
      held_col_q <= '0;
    end else begin
      seen_q     <= seen_d;
      held_row_q <= held_row_d;
      held_col_q <= held_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      win_q     <= win_d;
      left_up_q <= win_q.up1;
      prev_v_q  <= value_i;
      prev2_v_q <= prev_v_q;
    end
  end

  assign mem_we_o    = ctl_i.valid;
  assign mem_waddr_o = col_i;
  assign mem_wdata_o = '{up1: value_i, up2: win_q.up1};

  assign push_o          = ctl_i.valid && final_cell && seen_c;
  assign push_data_o.row = PEAK_W'(32'(hr_c));
  assign push_data_o.col = PEAK_W'(32'(hc_c));

endmodule

### rtl/gpcf_out_fifo.sv
// ----------------------------------------------------------------------------
// gpcf_out_fifo
// Two-entry result queue between the judge stage and the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpcf_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gpcf_pkg::peak_t push_data_i,
  input  logic            pop_i,
  output logic            valid_o,
  output gpcf_pkg::peak_t data_o,
  output logic [1:0]      count_o
);
  import gpcf_pkg::*;

  peak_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign do_pop = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = 2'(count_q + {1'b0, push_i} - {1'b0, do_pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

### rtl/gpcf_checker.sv
// ----------------------------------------------------------------------------
// gpcf_checker
// Port-level checks of the grid peak cell finder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "grid_peak_cell_finder_assert.svh"

module gpcf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cell_valid_i,
  input logic       cell_ready_i,
  input logic       peak_valid_i,
  input logic       peak_ready_i,
  input logic [5:0] peak_row_i,
  input logic [5:0] peak_col_i
);

  logic cell_fire;

  assign cell_fire = cell_valid_i && cell_ready_i;

  `GPCF_ASSERT_NEXT(a_peak_hold, peak_valid_i && !peak_ready_i, peak_valid_i && $stable(peak_row_i) && $stable(peak_col_i), "peak transaction changed while stalled")
  `GPCF_ASSERT_NOW(a_result_latency, $rose(peak_valid_i), $past(cell_fire, 2), "result without a cell transaction two cycles before")
  `GPCF_ASSERT_NOW(a_stall_needs_backlog, !cell_ready_i, peak_valid_i, "cell input stalled with no result pending")

endmodule

bind grid_peak_cell_finder gpcf_checker u_gpcf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cell_valid_i (cell_i.valid),
  .cell_ready_i (cell_i.ready),
  .peak_valid_i (peak_o.valid),
  .peak_ready_i (peak_o.ready),
  .peak_row_i   (peak_o.peak_row),
  .peak_col_i   (peak_o.peak_col)
);
